FILE: hw/rtl/assert_macros.svh
// Assertion helpers. Every user has clk and rst (synchronous, active high).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, evaluated even while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/irpd_pkg.sv
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int INTERVAL_W  = 16;
  localparam int BYTE_W      = 8;
  localparam int FRAME_BYTES = 4;
  localparam int FRAME_BITS  = FRAME_BYTES * BYTE_W;
  localparam int CNT_W       = $clog2(FRAME_BITS);
  localparam int SLOT_W      = $clog2(FRAME_BYTES);
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_BITS    = FRAME_BITS + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [INTERVAL_W-1:0] START_MIN_RST = INTERVAL_W'(8000);
  localparam logic [INTERVAL_W-1:0] START_MAX_RST = INTERVAL_W'(14000);
  localparam logic [INTERVAL_W-1:0] ONE_MAX_RST   = INTERVAL_W'(3000);
  localparam logic [INTERVAL_W-1:0] BIT_SPLIT_RST = INTERVAL_W'(1450);
  localparam logic [INTERVAL_W-1:0] ZERO_MIN_RST  = INTERVAL_W'(700);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MIN = 3'd0,
    REG_START_MAX = 3'd1,
    REG_ONE_MAX   = 3'd2,
    REG_BIT_SPLIT = 3'd3,
    REG_ZERO_MIN  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] start_min;
    logic [INTERVAL_W-1:0] start_max;
    logic [INTERVAL_W-1:0] one_max;
    logic [INTERVAL_W-1:0] bit_split;
    logic [INTERVAL_W-1:0] zero_min;
  } cfg_t;

  // Interval class; leader already takes priority over the bit windows.
  typedef struct packed {
    logic leader;
    logic one;
    logic zero;
  } class_t;

endpackage

FILE: hw/rtl/irpd_cfg.sv
`timescale 1ns / 1ps

module irpd_cfg
  import irpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [INTERVAL_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_min <= START_MIN_RST;
      cfg.start_max <= START_MAX_RST;
      cfg.one_max   <= ONE_MAX_RST;
      cfg.bit_split <= BIT_SPLIT_RST;
      cfg.zero_min  <= ZERO_MIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_MIN: cfg.start_min <= cfg_data;
        REG_START_MAX: cfg.start_max <= cfg_data;
        REG_ONE_MAX:   cfg.one_max   <= cfg_data;
        REG_BIT_SPLIT: cfg.bit_split <= cfg_data;
        REG_ZERO_MIN:  cfg.zero_min  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/irpd_classify.sv
`timescale 1ns / 1ps

module irpd_classify
  import irpd_pkg::*;
(
  input  logic [INTERVAL_W-1:0] interval,
  input  cfg_t                  cfg,
  output class_t                cls
);

  logic is_leader;

  assign is_leader  = (interval > cfg.start_min) && (interval < cfg.start_max);
  assign cls.leader = is_leader;
  // bit_split itself falls in neither window
  assign cls.one    = !is_leader && (interval > cfg.bit_split) &&
                      (interval < cfg.one_max);
  assign cls.zero   = !is_leader && (interval > cfg.zero_min) &&
                      (interval < cfg.bit_split);

endmodule

FILE: hw/rtl/irpd_frame.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module irpd_frame
  import irpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  class_t                 cls,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

  logic [BYTE_W-1:0] frame_bytes [FRAME_BYTES];
  logic [BYTE_W-1:0] frame_bytes_next [FRAME_BYTES];
  logic [CNT_W-1:0]  bit_count;
  logic              frame_armed;
  logic [SLOT_W-1:0] slot;
  logic              take_bit;
  logic              emit;
  logic              fire;
  logic              frame_ok;

  assign slot     = bit_count[CNT_W-1 -: SLOT_W];
  assign take_bit = frame_armed && (cls.one || cls.zero);
  assign emit     = take_bit && (bit_count == LAST_BIT);
  // only an item that completes a frame waits on the output register
  assign in_ready = !emit || !m_tvalid || m_tready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_bytes_next[i] = frame_bytes[i];
    end
    if (take_bit) begin
      frame_bytes_next[slot] = {cls.one, frame_bytes[slot][BYTE_W-1:1]};
    end
  end

  assign frame_ok = (frame_bytes_next[3] == ~frame_bytes_next[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count   <= '0;
      frame_armed <= 1'b0;
    end else if (fire) begin
      if (cls.leader) begin
        bit_count   <= '0;
        frame_armed <= 1'b1;
      end else if (take_bit) begin
        bit_count <= bit_count + 1'b1;
        if (emit) begin
          frame_armed <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame_bytes[i] <= frame_bytes_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      m_tdata <= {(OUT_TDATA_W - OUT_BITS)'(0), frame_ok, frame_bytes_next[3],
                  frame_bytes_next[2], frame_bytes_next[1], frame_bytes_next[0]};
    end
  end

  `ASSERT_CLK(a_emit_needs_arm, (fire && emit) |-> frame_armed, "frame emitted while not armed")
  `ASSERT_CLK(a_disarm_after_emit, (fire && emit) |=> (!frame_armed && bit_count == '0),
              "frame not disarmed after result")
  `ASSERT_CLK(a_leader_arms, (fire && cls.leader) |=> (frame_armed && bit_count == '0),
              "leader did not arm the frame")
  `ASSERT_CLK(a_result_source, $rose(m_tvalid) |-> $past(fire && emit),
              "result appeared without a completed frame")

endmodule

FILE: hw/rtl/ir_pulse_distance_decoder.sv
`timescale 1ns / 1ps
// The 32nd bit interval passes the input register (interval_q); once the frame stage
//   accepts it, the result is registered in m_tdata and m_tvalid rises.
// Throughput: 1 interval per cycle; the only stall is a completed frame while
//   the previous result still sits unread in the output register.
// Reset (rst, synchronous, active high): thresholds return to their defaults,
//   frame disarmed, bit count cleared, input and output registers empty.
module ir_pulse_distance_decoder
  import irpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [INTERVAL_W-1:0]  s_tdata,   // [15:0] edge_interval
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] address_byte, [15:8] address_check, [23:16] command_byte,
  // [31:24] command_check, [32] frame_ok, [39:33] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [INTERVAL_W-1:0]  cfg_data
);

  cfg_t                  cfg;
  class_t                cls;
  logic                  in_valid_q;
  logic [INTERVAL_W-1:0] interval_q;
  logic                  proc_ready;

  assign s_tready = !in_valid_q || proc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid_q <= 1'b1;
    end else if (proc_ready) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      interval_q <= s_tdata;
    end
  end

  irpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  irpd_classify u_classify (
    .interval (interval_q),
    .cfg      (cfg),
    .cls      (cls)
  );

  irpd_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid_q),
    .in_ready (proc_ready),
    .cls      (cls),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
